/* sv/plir_pkg.sv */
// Package for the positional list block: sizes, mode and status codes,
// the per-cell select code and the command broadcast along the cell row.
// No dependencies.
package plir_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [31:0] word_t;

  localparam logic [2:0] MODE_INS  = 3'd0;
  localparam logic [2:0] MODE_DEL  = 3'd1;
  localparam logic [2:0] MODE_APP  = 3'd2;
  localparam logic [2:0] MODE_POP  = 3'd3;
  localparam logic [2:0] MODE_READ = 3'd4;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_RANGE      = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_EMPTY_READ = 2'd3;

  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_LOAD,
    SEL_HEAD
  } cell_sel_t;

  typedef enum logic [1:0] {
    CH_IDLE,
    CH_INS,
    CH_DEL,
    CH_ROT
  } chain_op_t;

  typedef struct packed {
    chain_op_t         op;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  len;
    word_t             value;
  } chain_cmd_t;

  // entry count as shown on the 5-bit count field
  function automatic logic [4:0] to_count(input logic [CNT_W-1:0] n);
    logic [CNT_W+4:0] e;
    e = {5'b0, n};
    return e[4:0];
  endfunction

endpackage

/* sv/plir_cell.sv */
// One storage cell of the list row: holds one word and picks its next value
// from itself, a neighbor, the head cell or the broadcast load word.
// Depends on plir_pkg.
module plir_cell (
  input  logic                clk,
  input  plir_pkg::cell_sel_t sel,
  input  plir_pkg::word_t     left,
  input  plir_pkg::word_t     right,
  input  plir_pkg::word_t     head,
  input  plir_pkg::word_t     load,
  output plir_pkg::word_t     q
);
  import plir_pkg::*;

  word_t data_r;
  word_t data_nxt;

  always_comb begin
    case (sel)
      SEL_HOLD:  data_nxt = data_r;
      SEL_LEFT:  data_nxt = left;
      SEL_RIGHT: data_nxt = right;
      SEL_LOAD:  data_nxt = load;
      SEL_HEAD:  data_nxt = head;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

/* sv/plir_chain.sv */
// Row of list cells. Decodes the broadcast command into a select per cell:
// insert opens a gap, remove closes one, rotate cycles the used part by one.
// Depends on plir_pkg and plir_cell.
module plir_chain (
  input  logic                 clk,
  input  plir_pkg::chain_cmd_t cmd,
  output plir_pkg::word_t      data_q [plir_pkg::CAPACITY]
);
  import plir_pkg::*;

  logic [CNT_W-1:0] tail;
  cell_sel_t        sel [CAPACITY];

  assign tail = cmd.len - CNT_W'(1);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w;
    word_t right_w;

    always_comb begin
      case (cmd.op)
        CH_INS: begin
          if (IDX_W'(i) > cmd.idx) sel[i] = SEL_LEFT;
          else if (IDX_W'(i) == cmd.idx) sel[i] = SEL_LOAD;
          else sel[i] = SEL_HOLD;
        end
        CH_DEL: begin
          if (IDX_W'(i) >= cmd.idx && CNT_W'(i) < tail) sel[i] = SEL_RIGHT;
          else sel[i] = SEL_HOLD;
        end
        CH_ROT: begin
          if (CNT_W'(i) < tail) sel[i] = SEL_RIGHT;
          else if (CNT_W'(i) == tail) sel[i] = SEL_HEAD;
          else sel[i] = SEL_HOLD;
        end
        default: sel[i] = SEL_HOLD;
      endcase
    end

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = data_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = data_q[i+1];
    end

    plir_cell u_cell (
      .clk   (clk),
      .sel   (sel[i]),
      .left  (left_w),
      .right (right_w),
      .head  (data_q[0]),
      .load  (cmd.value),
      .q     (data_q[i])
    );
  end

endmodule

/* sv/positional_list_insert_remove.sv */
// Ordered list of up to CAPACITY signed words with 1-based positions, kept in
// a row of cells that all shift together. Insert, remove, append and pop
// each give one word; a full output register sits on the result side, so a
// new word is taken whenever that register is empty or is being drained and
// no read-out is running. Once a read is accepted, read-out streams one word
// per cycle while the result register is free, head first, by rotating the
// used cells; the input stays closed until the last entry has been given.
// An empty read gives one word with the empty-read status.
module positional_list_insert_remove (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_mode,
  input  logic signed [31:0]  in_value,
  input  logic [7:0]          in_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_element,
  output logic [4:0]          out_count,
  output logic                out_last
);
  import plir_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] rd_r, rd_nxt;
  logic             ov_r, ov_nxt;
  logic [1:0]       status_r, status_nxt;
  word_t            elem_r, elem_nxt;
  logic [4:0]       count_r;
  logic             last_r, last_nxt;

  chain_cmd_t       cmd;
  word_t            data_q [CAPACITY];
  logic             slot_free;
  logic             acc;
  logic             ld;
  logic [8:0]       pos9;
  logic [8:0]       len9;
  logic [7:0]       pos_m1;
  logic [CNT_W-1:0] tail;

  assign slot_free = !ov_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;
  assign pos9      = {1'b0, in_position};
  assign len9      = 9'(len_r);
  assign pos_m1    = in_position - 8'd1;
  assign tail      = len_r - CNT_W'(1);

  always_comb begin
    cmd.op     = CH_IDLE;
    cmd.idx    = '0;
    cmd.len    = len_r;
    cmd.value  = in_value;
    len_nxt    = len_r;
    state_nxt  = state_r;
    rd_nxt     = rd_r;
    ld         = 1'b0;
    status_nxt = ST_RANGE;
    elem_nxt   = '0;
    last_nxt   = 1'b1;

    if (state_r == ST_IDLE) begin
      if (acc) begin
        ld = 1'b1;
        case (in_mode)
          MODE_INS: begin
            if (pos9 == 9'd0 || pos9 > len9 + 9'd1) begin
              status_nxt = ST_RANGE;
            end else if (len9 >= 9'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_DONE;
              cmd.op     = CH_INS;
              cmd.idx    = pos_m1[IDX_W-1:0];
              len_nxt    = len_r + CNT_W'(1);
            end
          end
          MODE_DEL: begin
            if (pos9 == 9'd0 || pos9 > len9) begin
              status_nxt = ST_RANGE;
            end else begin
              status_nxt = ST_DONE;
              cmd.op     = CH_DEL;
              cmd.idx    = pos_m1[IDX_W-1:0];
              elem_nxt   = data_q[pos_m1[IDX_W-1:0]];
              len_nxt    = tail;
            end
          end
          MODE_APP: begin
            if (len9 >= 9'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_DONE;
              cmd.op     = CH_INS;
              cmd.idx    = len_r[IDX_W-1:0];
              len_nxt    = len_r + CNT_W'(1);
            end
          end
          MODE_POP: begin
            if (len_r == '0) begin
              status_nxt = ST_RANGE;
            end else begin
              status_nxt = ST_DONE;
              cmd.op     = CH_DEL;
              cmd.idx    = tail[IDX_W-1:0];
              elem_nxt   = data_q[tail[IDX_W-1:0]];
              len_nxt    = tail;
            end
          end
          MODE_READ: begin
            if (len_r == '0) begin
              status_nxt = ST_EMPTY_READ;
            end else begin
              // no word now; the stream starts next cycle
              ld        = 1'b0;
              state_nxt = ST_READ;
              rd_nxt    = '0;
            end
          end
          default: status_nxt = ST_RANGE;
        endcase
      end
    end else if (slot_free) begin
      // head word out, rotate so the next entry reaches cell 0
      ld         = 1'b1;
      status_nxt = ST_DONE;
      elem_nxt   = data_q[0];
      last_nxt   = (CNT_W'(rd_r) == tail);
      cmd.op     = CH_ROT;
      rd_nxt     = rd_r + IDX_W'(1);
      if (last_nxt) begin
        state_nxt = ST_IDLE;
        rd_nxt    = '0;
      end
    end

    ov_nxt = ld ? 1'b1 : (ov_r && !out_ready);
  end

  plir_chain u_chain (
    .clk    (clk),
    .cmd    (cmd),
    .data_q (data_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      rd_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      rd_r    <= rd_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      status_r <= status_nxt;
      elem_r   <= elem_nxt;
      count_r  <= to_count(len_nxt);
      last_r   <= last_nxt;
    end
  end

  assign out_valid   = ov_r;
  assign out_status  = status_r;
  assign out_element = elem_r;
  assign out_count   = count_r;
  assign out_last    = last_r;

endmodule

/* sv/plir_checker.sv */
// Port-level checks for the positional list block, bound to its top level.
// Depends on plir_pkg and positional_list_insert_remove.
module plir_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_element,
  input logic [4:0]         out_count,
  input logic               out_last
);
  import plir_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_element)
      && $stable(out_status) && $stable(out_last))
    else $error("result word changed while stalled");

  // a failed operation is always a single word
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_last)
    else $error("failure status without last");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_element == 32'sd0)
    else $error("failure status with nonzero element");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_count == 5'(CAPACITY))
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY_READ |-> out_count == 5'd0)
    else $error("empty read with nonzero count");

endmodule

bind positional_list_insert_remove plir_checker u_plir_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_status  (out_status),
  .out_element (out_element),
  .out_count   (out_count),
  .out_last    (out_last)
);
